FILE: hdl/radial_lens_distortion_map_assert.svh
// Assertion macros shared by the checker.
// RLDM_ASSERT_IMP: same-cycle implication, masked while reset is high.
// RLDM_ASSERT_NXT: next-cycle implication, also checked across reset.
`ifndef RADIAL_LENS_DISTORTION_MAP_ASSERT_SVH
`define RADIAL_LENS_DISTORTION_MAP_ASSERT_SVH
`define RLDM_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rldm checker: property failed");
`define RLDM_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("rldm checker: property failed");
`endif

FILE: hdl/rldm_pkg.sv
`timescale 1ns / 1ps
package rldm_pkg;

   // input coordinate width, whole pixels
   localparam int COORD_BITS = 12;

   // coordinate and offset widths (Q.4)
   localparam int PIX_W  = COORD_BITS + 4;
   localparam int DIFF_W = ((PIX_W > 16) ? PIX_W : 16) + 1;
   localparam int MAG_W  = DIFF_W - 1;
   localparam int SQ_W   = 2 * MAG_W;

   // r2 divider
   localparam int R2_W    = 20;
   localparam int QUO_W   = R2_W + 1;
   localparam int NUM_W   = SQ_W + 17;
   localparam int DEN_W   = 32;
   localparam int REM_W   = ((NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W) + 1;
   localparam int DIV_LAT = QUO_W + 1;
   localparam logic [QUO_W:0] R2_MAX = (QUO_W + 1)'((1 << R2_W) - 1);

   // radial factor
   localparam int K1R2_W = 16 + R2_W + 1;
   localparam int ACC_W  = 58;
   localparam int RAD_W  = 28;
   localparam logic signed [ACC_W-1:0] ACC_BIAS = ACC_W'(64'h0000_4000_2000_0000);

   // distortion products
   localparam int PROD_W = DIFF_W + RAD_W;
   localparam int RND_W  = PROD_W - 16;
   localparam int UD_W   = RND_W + 1;
   localparam int DU_W   = UD_W + 1;
   localparam logic signed [PROD_W-1:0] HALF_LSB = PROD_W'(32768);

   // output fields
   localparam int OUT_W = 18;
   localparam int LEN_W = 16;
   localparam logic signed [UD_W-1:0] OUT_MAX = UD_W'(131071);
   localparam logic signed [UD_W-1:0] OUT_MIN = UD_W'(-131072);

   // shift length square root
   localparam int SQ_IT   = 17;
   localparam int SQ_N_W  = 2 * SQ_IT;
   localparam int SQ_O_W  = SQ_IT + 1;
   localparam int SQ_LAT  = SQ_IT + 2;

   // pipeline depth, accept to result strobe
   localparam int FRONT_STAGES = 4;
   localparam int MID_STAGES   = 12;
   localparam int TOT_LAT = FRONT_STAGES + DIV_LAT + MID_STAGES + SQ_LAT + 1;

   // register map
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] REG_FOCAL_X  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FOCAL_Y  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CENTER_X = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CENTER_Y = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_K1       = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_K2       = 3'd5;

   // per-item geometry carried beside the divider and multipliers
   typedef struct packed {
      logic signed [DIFF_W-1:0] dx;
      logic signed [DIFF_W-1:0] dy;
      logic [PIX_W-1:0]         pu;
      logic [PIX_W-1:0]         pv;
   } geo_type;

   // finished fields carried beside the square root
   typedef struct packed {
      logic signed [OUT_W-1:0] uo;
      logic signed [OUT_W-1:0] vo;
      logic [R2_W-1:0]         r2;
      logic                    big;
   } tail_type;

   // saturate a distorted coordinate to the output field
   function automatic logic signed [OUT_W-1:0] clamp_out(input logic signed [UD_W-1:0] v);
      logic signed [UD_W-1:0] t;
      t = v;
      if (v > OUT_MAX) t = OUT_MAX;
      if (v < OUT_MIN) t = OUT_MIN;
      return OUT_W'(t);
   endfunction

endpackage

FILE: hdl/rldm_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage.
// Flags quotients that do not fit QUO_W bits.
module rldm_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  logic [rldm_pkg::NUM_W-1:0]     in_num,
   input  logic [rldm_pkg::DEN_W-1:0]     in_den,
   output logic                           out_valid,
   output logic [rldm_pkg::QUO_W-1:0]     out_quo,
   output logic                           out_ovf
);

   logic                          valid_ff [rldm_pkg::QUO_W+1];
   logic [rldm_pkg::REM_W-1:0]    rem_ff   [rldm_pkg::QUO_W+1];
   logic [rldm_pkg::DEN_W-1:0]    den_ff   [rldm_pkg::QUO_W+1];
   logic [rldm_pkg::QUO_W-1:0]    quo_ff   [rldm_pkg::QUO_W+1];
   logic                          ovf_ff   [rldm_pkg::QUO_W+1];

   // load stage: range check against den << QUO_W
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
      end
      rem_ff[0] <= rldm_pkg::REM_W'(in_num);
      den_ff[0] <= in_den;
      quo_ff[0] <= '0;
      ovf_ff[0] <= rldm_pkg::REM_W'(in_num) >=
                   (rldm_pkg::REM_W'(in_den) << rldm_pkg::QUO_W);
   end

   // one trial subtract per stage, MSB first
   for (genvar k = 1; k <= rldm_pkg::QUO_W; k++) begin : g_step
      localparam int SH = rldm_pkg::QUO_W - k;
      logic [rldm_pkg::REM_W:0] diff;
      logic                     take;

      assign diff = {1'b0, rem_ff[k-1]} -
                    {1'b0, (rldm_pkg::REM_W'(den_ff[k-1]) << SH)};
      assign take = ~diff[rldm_pkg::REM_W];

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= valid_ff[k-1];
         end
         rem_ff[k] <= take ? diff[rldm_pkg::REM_W-1:0] : rem_ff[k-1];
         den_ff[k] <= den_ff[k-1];
         quo_ff[k] <= {quo_ff[k-1][rldm_pkg::QUO_W-2:0], take};
         ovf_ff[k] <= ovf_ff[k-1];
      end
   end

   assign out_valid = valid_ff[rldm_pkg::QUO_W];
   assign out_quo   = quo_ff[rldm_pkg::QUO_W];
   assign out_ovf   = ovf_ff[rldm_pkg::QUO_W];

endmodule

FILE: hdl/rldm_sqrt.sv
`timescale 1ns / 1ps
// Pipelined integer square root, one result bit per stage,
// rounded to nearest in a last stage.
module rldm_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [rldm_pkg::SQ_N_W-1:0]   in_n,
   output logic                          out_valid,
   output logic [rldm_pkg::SQ_O_W-1:0]   out_root
);

   logic                          valid_ff [rldm_pkg::SQ_IT+1];
   logic [rldm_pkg::SQ_N_W-1:0]   n_ff     [rldm_pkg::SQ_IT+1];
   logic [rldm_pkg::SQ_N_W-1:0]   res_ff   [rldm_pkg::SQ_IT+1];
   logic                          out_valid_ff;
   logic [rldm_pkg::SQ_O_W-1:0]   out_root_ff;

   // load stage
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
      end
      n_ff[0]   <= in_n;
      res_ff[0] <= '0;
   end

   // digit-by-digit root, bit weight 4^(SQ_IT-k)
   for (genvar k = 1; k <= rldm_pkg::SQ_IT; k++) begin : g_step
      localparam int SH = 2 * (rldm_pkg::SQ_IT - k);
      logic [rldm_pkg::SQ_N_W-1:0] bitv;
      logic [rldm_pkg::SQ_N_W-1:0] trial;
      logic                        take;

      assign bitv  = rldm_pkg::SQ_N_W'(1) << SH;
      assign trial = res_ff[k-1] + bitv;
      assign take  = n_ff[k-1] >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= valid_ff[k-1];
         end
         n_ff[k]   <= take ? n_ff[k-1] - trial : n_ff[k-1];
         res_ff[k] <= take ? (res_ff[k-1] >> 1) + bitv : (res_ff[k-1] >> 1);
      end
   end

   // round up when the remainder exceeds the root
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= valid_ff[rldm_pkg::SQ_IT];
      end
      out_root_ff <= rldm_pkg::SQ_O_W'(res_ff[rldm_pkg::SQ_IT]) +
                     rldm_pkg::SQ_O_W'(n_ff[rldm_pkg::SQ_IT] > res_ff[rldm_pkg::SQ_IT]);
   end

   assign out_valid = out_valid_ff;
   assign out_root  = out_root_ff;

endmodule

FILE: hdl/radial_lens_distortion_map.sv
`timescale 1ns / 1ps
// Channel     Ports                                  Handshake
// request     req_pixel_u, req_pixel_v              start & !busy
// response    rsp_distorted_u/v, rsp_radius_squared, rsp_valid, one cycle
//             rsp_shift_length
// config      csr_index, csr_wdata                   csr_we
//
// One coordinate per clock while busy is low. The pipeline depth is
// set by the 22-stage r2 divider and the 19-stage shift-length square
// root. busy is high only during reset; reset empties the pipeline and
// restores the register defaults. The result side has no back-pressure.
module radial_lens_distortion_map (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [rldm_pkg::COORD_BITS-1:0]       req_pixel_u,
   input  logic [rldm_pkg::COORD_BITS-1:0]       req_pixel_v,
   output logic                                  rsp_valid,
   output logic signed [17:0]                    rsp_distorted_u,
   output logic signed [17:0]                    rsp_distorted_v,
   output logic [19:0]                           rsp_radius_squared,
   output logic [15:0]                           rsp_shift_length,
   input  logic                                  csr_we,
   input  logic [rldm_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [15:0]                           csr_wdata
);

   // configuration registers
   logic [15:0]        focal_x_ff, focal_y_ff, center_x_ff, center_y_ff;
   logic signed [15:0] radial_k1_ff, radial_k2_ff;
   logic [rldm_pkg::DEN_W-1:0] denx_ff, deny_ff;
   logic [15:0]        fx, fy;

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_x_ff   <= 16'd8000;
         focal_y_ff   <= 16'd8000;
         center_x_ff  <= 16'd5120;
         center_y_ff  <= 16'd3840;
         radial_k1_ff <= -16'sd4915;
         radial_k2_ff <= 16'sd1638;
      end else if (csr_we) begin
         case (csr_index)
            rldm_pkg::REG_FOCAL_X:  focal_x_ff   <= csr_wdata;
            rldm_pkg::REG_FOCAL_Y:  focal_y_ff   <= csr_wdata;
            rldm_pkg::REG_CENTER_X: center_x_ff  <= csr_wdata;
            rldm_pkg::REG_CENTER_Y: center_y_ff  <= csr_wdata;
            rldm_pkg::REG_K1:       radial_k1_ff <= $signed(csr_wdata);
            rldm_pkg::REG_K2:       radial_k2_ff <= $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   // focal length squared, zero read as one LSB
   assign fx = (focal_x_ff == 16'd0) ? 16'd1 : focal_x_ff;
   assign fy = (focal_y_ff == 16'd0) ? 16'd1 : focal_y_ff;

   always_ff @(posedge clock) begin
      denx_ff <= fx * fx;
      deny_ff <= fy * fy;
   end

   assign busy = reset;

   // front end: offsets, magnitudes, squares, numerators
   logic                                v1_ff, v2_ff, v3_ff, v4_ff;
   rldm_pkg::geo_type                   geo1_ff, geo2_ff, geo3_ff, geo4_ff, geo1_in;
   logic [rldm_pkg::MAG_W-1:0]          magx2_ff, magy2_ff;
   logic [rldm_pkg::SQ_W-1:0]           sqx3_ff, sqy3_ff;
   logic [rldm_pkg::NUM_W-1:0]          numx4_ff, numy4_ff;

   always_comb begin
      geo1_in.pu = {rldm_pkg::PIX_W'(req_pixel_u) << 4};
      geo1_in.pv = {rldm_pkg::PIX_W'(req_pixel_v) << 4};
      geo1_in.dx = $signed(rldm_pkg::DIFF_W'(geo1_in.pu)) -
                   $signed(rldm_pkg::DIFF_W'(center_x_ff));
      geo1_in.dy = $signed(rldm_pkg::DIFF_W'(geo1_in.pv)) -
                   $signed(rldm_pkg::DIFF_W'(center_y_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= start & ~busy;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
      geo1_ff  <= geo1_in;
      geo2_ff  <= geo1_ff;
      magx2_ff <= geo1_ff.dx[rldm_pkg::DIFF_W-1] ? rldm_pkg::MAG_W'(-geo1_ff.dx)
                                                 : rldm_pkg::MAG_W'(geo1_ff.dx);
      magy2_ff <= geo1_ff.dy[rldm_pkg::DIFF_W-1] ? rldm_pkg::MAG_W'(-geo1_ff.dy)
                                                 : rldm_pkg::MAG_W'(geo1_ff.dy);
      geo3_ff  <= geo2_ff;
      sqx3_ff  <= magx2_ff * magx2_ff;
      sqy3_ff  <= magy2_ff * magy2_ff;
      geo4_ff  <= geo3_ff;
      // d^2 * 2^16 + den/2, rounding half up in the divide
      numx4_ff <= {1'b0, sqx3_ff, 16'b0} + rldm_pkg::NUM_W'(denx_ff >> 1);
      numy4_ff <= {1'b0, sqy3_ff, 16'b0} + rldm_pkg::NUM_W'(deny_ff >> 1);
   end

   // r2 terms
   logic                          divx_valid, divy_valid, divx_ovf, divy_ovf;
   logic [rldm_pkg::QUO_W-1:0]    divx_quo, divy_quo;

   rldm_div u_div_x (
      .clock(clock), .reset(reset), .in_valid(v4_ff), .in_num(numx4_ff),
      .in_den(denx_ff), .out_valid(divx_valid), .out_quo(divx_quo), .out_ovf(divx_ovf)
   );

   rldm_div u_div_y (
      .clock(clock), .reset(reset), .in_valid(v4_ff), .in_num(numy4_ff),
      .in_den(deny_ff), .out_valid(divy_valid), .out_quo(divy_quo), .out_ovf(divy_ovf)
   );

   // geometry delay matched to the divider
   rldm_pkg::geo_type geo_dly_ff [rldm_pkg::DIV_LAT];

   always_ff @(posedge clock) begin
      geo_dly_ff[0] <= geo4_ff;
      for (int i = 1; i < rldm_pkg::DIV_LAT; i++) begin
         geo_dly_ff[i] <= geo_dly_ff[i-1];
      end
   end

   // middle: r2 sum, radial factor, distorted point, shift terms
   logic [rldm_pkg::QUO_W:0]           r2sum;
   logic                               v5_ff, v6_ff, v7_ff, v8_ff, v9_ff, v10_ff;
   logic                               v11_ff, v12_ff, v13_ff, v14_ff, v15_ff, v16_ff;
   rldm_pkg::geo_type                  geo5_ff, geo6_ff, geo7_ff, geo8_ff, geo9_ff;
   rldm_pkg::geo_type                  geo10_ff, geo11_ff, geo12_ff;
   logic [rldm_pkg::R2_W-1:0]          r2_5_ff, r2_6_ff, r2_7_ff, r2_8_ff, r2_9_ff;
   logic [rldm_pkg::R2_W-1:0]          r2_10_ff, r2_11_ff, r2_12_ff, r2_13_ff;
   logic [rldm_pkg::R2_W-1:0]          r2_14_ff, r2_15_ff, r2_16_ff;
   logic [2*rldm_pkg::R2_W-1:0]        r2sq6_ff;
   logic signed [rldm_pkg::K1R2_W-1:0] k1r2_6_ff, k1r2_7_ff, k1r2_8_ff;
   logic signed [rldm_pkg::K1R2_W-1:0] phi7_ff, plo7_ff;
   logic signed [rldm_pkg::ACC_W-1:0]  k2t8_ff, acc9;
   logic signed [rldm_pkg::RAD_W-1:0]  radial9_ff;
   logic signed [rldm_pkg::PROD_W-1:0] prodx10_ff, prody10_ff;
   logic signed [rldm_pkg::RND_W-1:0]  rndx11_ff, rndy11_ff;
   logic signed [rldm_pkg::UD_W-1:0]   ud12_ff, vd12_ff;
   logic signed [rldm_pkg::DU_W-1:0]   du13_ff, dv13_ff;
   logic signed [rldm_pkg::OUT_W-1:0]  uo13_ff, vo13_ff, uo14_ff, vo14_ff;
   logic signed [rldm_pkg::OUT_W-1:0]  uo15_ff, vo15_ff, uo16_ff, vo16_ff;
   logic [rldm_pkg::DU_W-1:0]          adu_in, adv_in;
   logic [15:0]                        adu14_ff, adv14_ff;
   logic                               big14_ff, big15_ff, big16_ff;
   logic [31:0]                        squ15_ff, sqv15_ff;
   logic [rldm_pkg::SQ_N_W-1:0]        n16_ff;

   assign r2sum = (rldm_pkg::QUO_W + 1)'(divx_quo) + (rldm_pkg::QUO_W + 1)'(divy_quo);

   assign acc9 = rldm_pkg::ACC_BIAS + (rldm_pkg::ACC_W'(k1r2_8_ff) <<< 16) + k2t8_ff;

   assign adu_in = du13_ff[rldm_pkg::DU_W-1] ? rldm_pkg::DU_W'(-du13_ff)
                                             : rldm_pkg::DU_W'(du13_ff);
   assign adv_in = dv13_ff[rldm_pkg::DU_W-1] ? rldm_pkg::DU_W'(-dv13_ff)
                                             : rldm_pkg::DU_W'(dv13_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff  <= 1'b0;
         v6_ff  <= 1'b0;
         v7_ff  <= 1'b0;
         v8_ff  <= 1'b0;
         v9_ff  <= 1'b0;
         v10_ff <= 1'b0;
         v11_ff <= 1'b0;
         v12_ff <= 1'b0;
         v13_ff <= 1'b0;
         v14_ff <= 1'b0;
         v15_ff <= 1'b0;
         v16_ff <= 1'b0;
      end else begin
         v5_ff  <= divx_valid & divy_valid;
         v6_ff  <= v5_ff;
         v7_ff  <= v6_ff;
         v8_ff  <= v7_ff;
         v9_ff  <= v8_ff;
         v10_ff <= v9_ff;
         v11_ff <= v10_ff;
         v12_ff <= v11_ff;
         v13_ff <= v12_ff;
         v14_ff <= v13_ff;
         v15_ff <= v14_ff;
         v16_ff <= v15_ff;
      end

      // saturated r2
      geo5_ff <= geo_dly_ff[rldm_pkg::DIV_LAT-1];
      r2_5_ff <= (divx_ovf | divy_ovf | (r2sum > rldm_pkg::R2_MAX))
                 ? rldm_pkg::R2_W'(rldm_pkg::R2_MAX) : rldm_pkg::R2_W'(r2sum);

      // r2^2 and k1*r2
      geo6_ff   <= geo5_ff;
      r2_6_ff   <= r2_5_ff;
      r2sq6_ff  <= r2_5_ff * r2_5_ff;
      k1r2_6_ff <= radial_k1_ff * $signed({1'b0, r2_5_ff});

      // k2*r2^2 in two halves
      geo7_ff   <= geo6_ff;
      r2_7_ff   <= r2_6_ff;
      k1r2_7_ff <= k1r2_6_ff;
      phi7_ff   <= radial_k2_ff *
                   $signed({1'b0, r2sq6_ff[2*rldm_pkg::R2_W-1:rldm_pkg::R2_W]});
      plo7_ff   <= radial_k2_ff * $signed({1'b0, r2sq6_ff[rldm_pkg::R2_W-1:0]});

      geo8_ff   <= geo7_ff;
      r2_8_ff   <= r2_7_ff;
      k1r2_8_ff <= k1r2_7_ff;
      k2t8_ff   <= (rldm_pkg::ACC_W'(phi7_ff) <<< rldm_pkg::R2_W) +
                   rldm_pkg::ACC_W'(plo7_ff);

      // radial factor, Q.46 rounded to Q.16
      geo9_ff    <= geo8_ff;
      r2_9_ff    <= r2_8_ff;
      radial9_ff <= rldm_pkg::RAD_W'(acc9 >>> 30);

      geo10_ff   <= geo9_ff;
      r2_10_ff   <= r2_9_ff;
      prodx10_ff <= rldm_pkg::PROD_W'(geo9_ff.dx * radial9_ff);
      prody10_ff <= rldm_pkg::PROD_W'(geo9_ff.dy * radial9_ff);

      geo11_ff  <= geo10_ff;
      r2_11_ff  <= r2_10_ff;
      rndx11_ff <= rldm_pkg::RND_W'((prodx10_ff + rldm_pkg::HALF_LSB) >>> 16);
      rndy11_ff <= rldm_pkg::RND_W'((prody10_ff + rldm_pkg::HALF_LSB) >>> 16);

      // back to pixel units
      geo12_ff <= geo11_ff;
      r2_12_ff <= r2_11_ff;
      ud12_ff  <= rldm_pkg::UD_W'(rndx11_ff) + $signed(rldm_pkg::UD_W'(center_x_ff));
      vd12_ff  <= rldm_pkg::UD_W'(rndy11_ff) + $signed(rldm_pkg::UD_W'(center_y_ff));

      // shift from the input, saturated outputs
      r2_13_ff <= r2_12_ff;
      du13_ff  <= rldm_pkg::DU_W'(ud12_ff) - $signed(rldm_pkg::DU_W'(geo12_ff.pu));
      dv13_ff  <= rldm_pkg::DU_W'(vd12_ff) - $signed(rldm_pkg::DU_W'(geo12_ff.pv));
      uo13_ff  <= rldm_pkg::clamp_out(ud12_ff);
      vo13_ff  <= rldm_pkg::clamp_out(vd12_ff);

      // any axis past 16 bits saturates the length
      r2_14_ff <= r2_13_ff;
      uo14_ff  <= uo13_ff;
      vo14_ff  <= vo13_ff;
      adu14_ff <= adu_in[15:0];
      adv14_ff <= adv_in[15:0];
      big14_ff <= (|adu_in[rldm_pkg::DU_W-1:16]) | (|adv_in[rldm_pkg::DU_W-1:16]);

      r2_15_ff <= r2_14_ff;
      uo15_ff  <= uo14_ff;
      vo15_ff  <= vo14_ff;
      big15_ff <= big14_ff;
      squ15_ff <= adu14_ff * adu14_ff;
      sqv15_ff <= adv14_ff * adv14_ff;

      r2_16_ff <= r2_15_ff;
      uo16_ff  <= uo15_ff;
      vo16_ff  <= vo15_ff;
      big16_ff <= big15_ff;
      n16_ff   <= rldm_pkg::SQ_N_W'(squ15_ff) + rldm_pkg::SQ_N_W'(sqv15_ff);
   end

   // shift length
   logic                           sq_valid;
   logic [rldm_pkg::SQ_O_W-1:0]    sq_root;
   rldm_pkg::tail_type             tail16, tail_dly_ff [rldm_pkg::SQ_LAT], tail_out;

   rldm_sqrt u_sqrt (
      .clock(clock), .reset(reset), .in_valid(v16_ff), .in_n(n16_ff),
      .out_valid(sq_valid), .out_root(sq_root)
   );

   always_comb begin
      tail16.uo  = uo16_ff;
      tail16.vo  = vo16_ff;
      tail16.r2  = r2_16_ff;
      tail16.big = big16_ff;
   end

   always_ff @(posedge clock) begin
      tail_dly_ff[0] <= tail16;
      for (int i = 1; i < rldm_pkg::SQ_LAT; i++) begin
         tail_dly_ff[i] <= tail_dly_ff[i-1];
      end
   end

   assign tail_out = tail_dly_ff[rldm_pkg::SQ_LAT-1];

   // result register
   logic                               rsp_valid_ff;
   logic signed [rldm_pkg::OUT_W-1:0]  rsp_u_ff, rsp_v_ff;
   logic [rldm_pkg::R2_W-1:0]          rsp_r2_ff;
   logic [rldm_pkg::LEN_W-1:0]         rsp_len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= sq_valid;
      end
      rsp_u_ff   <= tail_out.uo;
      rsp_v_ff   <= tail_out.vo;
      rsp_r2_ff  <= tail_out.r2;
      rsp_len_ff <= (tail_out.big | (|sq_root[rldm_pkg::SQ_O_W-1:rldm_pkg::LEN_W]))
                    ? {rldm_pkg::LEN_W{1'b1}} : sq_root[rldm_pkg::LEN_W-1:0];
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_distorted_u    = rsp_u_ff;
   assign rsp_distorted_v    = rsp_v_ff;
   assign rsp_radius_squared = rsp_r2_ff;
   assign rsp_shift_length   = rsp_len_ff;

endmodule

FILE: hdl/rldm_checker.sv
`timescale 1ns / 1ps
`include "radial_lens_distortion_map_assert.svh"
// Port-level checks on the distortion map.
module rldm_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  start,
   input logic                                  busy,
   input logic [rldm_pkg::COORD_BITS-1:0]       req_pixel_u,
   input logic [rldm_pkg::COORD_BITS-1:0]       req_pixel_v,
   input logic                                  rsp_valid,
   input logic signed [17:0]                    rsp_distorted_u,
   input logic signed [17:0]                    rsp_distorted_v,
   input logic [19:0]                           rsp_radius_squared,
   input logic [15:0]                           rsp_shift_length,
   input logic                                  csr_we,
   input logic [rldm_pkg::CSR_IDX_W-1:0]        csr_index,
   input logic [15:0]                           csr_wdata
);

   // every result traces back to a transaction a fixed depth earlier
   `RLDM_ASSERT_IMP(a_fixed_latency, rsp_valid, $past(start && !busy, rldm_pkg::TOT_LAT))

   // reset empties the pipeline
   `RLDM_ASSERT_NXT(a_reset_flush, reset, !rsp_valid)

   // on the optical axis the factor is exactly one, so no shift
   `RLDM_ASSERT_IMP(a_axis_no_shift, rsp_valid && (rsp_radius_squared == 20'd0), rsp_shift_length == 16'd0)

endmodule

bind radial_lens_distortion_map rldm_checker u_rldm_checker (.*);

FILE: tb/sv/tb_radial_lens_distortion_map.sv
`timescale 1ns / 1ps
module tb_radial_lens_distortion_map;

   localparam int LATENCY = rldm_pkg::TOT_LAT;
   localparam int CYCLE_LIMIT = 400000;

   // indexes outside the register map
   localparam logic [rldm_pkg::CSR_IDX_W-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [rldm_pkg::CSR_IDX_W-1:0] REG_SPARE_HI = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [rldm_pkg::COORD_BITS-1:0] req_pixel_u = '0;
   logic [rldm_pkg::COORD_BITS-1:0] req_pixel_v = '0;
   logic rsp_valid;
   logic signed [17:0] rsp_distorted_u;
   logic signed [17:0] rsp_distorted_v;
   logic [19:0] rsp_radius_squared;
   logic [15:0] rsp_shift_length;
   logic csr_we = 1'b0;
   logic [rldm_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [15:0] csr_wdata = '0;

   typedef struct {
      logic signed [17:0] du;
      logic signed [17:0] dv;
      logic [19:0] r2;
      logic [15:0] len;
   } mapped_point_type;

   mapped_point_type pending_points[$];

   // shadow of the lens registers
   logic [15:0] lens_fx, lens_fy, lens_cx, lens_cy;
   logic signed [15:0] lens_k1, lens_k2;

   int error_count = 0;
   int point_count = 0;
   int checked_count = 0;
   int config_count = 0;
   longint cycle_count = 0;
   bit calm_sender = 1'b0;

   radial_lens_distortion_map DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_pixel_u(req_pixel_u), .req_pixel_v(req_pixel_v),
      .rsp_valid(rsp_valid), .rsp_distorted_u(rsp_distorted_u),
      .rsp_distorted_v(rsp_distorted_v), .rsp_radius_squared(rsp_radius_squared),
      .rsp_shift_length(rsp_shift_length),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // floor division by 2**s for signed values
   function automatic longint floor_div_pow2(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint unsigned axis_r2(longint d, logic [15:0] focal);
      longint unsigned mag, f, den;
      mag = (d < 0) ? -d : d;
      f = (focal == 0) ? 1 : focal;
      den = f * f;
      return ((mag * mag << 16) + den / 2) / den;
   endfunction

   function automatic longint unsigned round_sqrt(longint unsigned n);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= root + bitv) begin
            n -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      if (n > root) root++;
      return root;
   endfunction

   function automatic logic signed [17:0] sat18(longint v);
      if (v > 131071) return 18'sd131071;
      if (v < -131072) return -18'sd131072;
      return v[17:0];
   endfunction

   // expected mapping of one pixel under the current lens registers
   function automatic mapped_point_type map_pixel(logic [rldm_pkg::COORD_BITS-1:0] u,
                                                  logic [rldm_pkg::COORD_BITS-1:0] v);
      mapped_point_type m;
      longint pu, pv, dx, dy, r2s, acc, radial, ud, vd, du, dv;
      longint unsigned r2, len;
      pu = longint'(u) * 16;
      pv = longint'(v) * 16;
      dx = pu - longint'(lens_cx);
      dy = pv - longint'(lens_cy);
      r2 = axis_r2(dx, lens_fx) + axis_r2(dy, lens_fy);
      if (r2 > 1048575) r2 = 1048575;
      r2s = r2;
      acc = (64'sd1 <<< 46) + longint'(lens_k1) * r2s * 65536
            + longint'(lens_k2) * r2s * r2s;
      radial = floor_div_pow2(acc + (64'sd1 <<< 29), 30);
      ud = floor_div_pow2(dx * radial + 32768, 16) + longint'(lens_cx);
      vd = floor_div_pow2(dy * radial + 32768, 16) + longint'(lens_cy);
      du = (ud - pu < 0) ? pu - ud : ud - pu;
      dv = (vd - pv < 0) ? pv - vd : vd - pv;
      len = round_sqrt(longint'(du) * du + longint'(dv) * dv);
      if (len > 65535) len = 65535;
      m.du = sat18(ud);
      m.dv = sat18(vd);
      m.r2 = r2[19:0];
      m.len = len[15:0];
      return m;
   endfunction

   // result checker
   always @(posedge clock) begin
      mapped_point_type exp_pt;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid) begin
         if (pending_points.size() == 0) begin
            $error("unexpected result transaction");
            error_count++;
         end else begin
            exp_pt = pending_points.pop_front();
            checked_count++;
            if (rsp_distorted_u !== exp_pt.du) begin
               $error("distorted_u expected %0d actual %0d", exp_pt.du, rsp_distorted_u);
               error_count++;
            end
            if (rsp_distorted_v !== exp_pt.dv) begin
               $error("distorted_v expected %0d actual %0d", exp_pt.dv, rsp_distorted_v);
               error_count++;
            end
            if (rsp_radius_squared !== exp_pt.r2) begin
               $error("radius_squared expected %0d actual %0d", exp_pt.r2,
                      rsp_radius_squared);
               error_count++;
            end
            if (rsp_shift_length !== exp_pt.len) begin
               $error("shift_length expected %0d actual %0d", exp_pt.len,
                      rsp_shift_length);
               error_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("tb: failure");
         $finish;
      end
   end

   // send one pixel transaction, with random idle cycles unless calm_sender is set
   task automatic send_pixel(input logic [rldm_pkg::COORD_BITS-1:0] u,
                             input logic [rldm_pkg::COORD_BITS-1:0] v);
      while (!calm_sender && $urandom_range(99) < 9) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_pixel_u <= u;
      req_pixel_v <= v;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_points.insert(pending_points.size(), map_pixel(u, v));
      point_count++;
      @(negedge clock);
   endtask

   // drop start and let the pipeline empty
   task automatic drain_pipeline();
      start <= 1'b0;
      @(negedge clock);
      while (pending_points.size() != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   task automatic write_lens_reg(input logic [rldm_pkg::CSR_IDX_W-1:0] idx,
                                 input logic [15:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
      config_count++;
      case (idx)
         rldm_pkg::REG_FOCAL_X: lens_fx = val;
         rldm_pkg::REG_FOCAL_Y: lens_fy = val;
         rldm_pkg::REG_CENTER_X: lens_cx = val;
         rldm_pkg::REG_CENTER_Y: lens_cy = val;
         rldm_pkg::REG_K1: lens_k1 = val;
         rldm_pkg::REG_K2: lens_k2 = val;
         default: ;
      endcase
   endtask

   task automatic set_lens(input logic [15:0] fx, input logic [15:0] fy,
                           input logic [15:0] cx, input logic [15:0] cy,
                           input logic [15:0] k1, input logic [15:0] k2);
      drain_pipeline();
      write_lens_reg(rldm_pkg::REG_FOCAL_X, fx);
      write_lens_reg(rldm_pkg::REG_FOCAL_Y, fy);
      write_lens_reg(rldm_pkg::REG_CENTER_X, cx);
      write_lens_reg(rldm_pkg::REG_CENTER_Y, cy);
      write_lens_reg(rldm_pkg::REG_K1, k1);
      write_lens_reg(rldm_pkg::REG_K2, k2);
   endtask

   task automatic test_reset_defaults();
      send_pixel(0, 0);
      send_pixel(4095, 4095);
      send_pixel(320, 240);
      send_pixel(0, 4095);
      send_pixel(4095, 0);
   endtask

   task automatic test_corners_and_extremes();
      // strong barrel and pincushion, zero focal treated as one LSB
      set_lens(16, 16, 0, 65535, 16'h8000, 16'h7FFF);
      send_pixel(0, 0);
      send_pixel(4095, 4095);
      send_pixel(2048, 2048);
      set_lens(0, 0, 32768, 32768, 16'h7FFF, 16'h8000);
      send_pixel(0, 4095);
      send_pixel(4095, 0);
      send_pixel(2048, 2048);
      set_lens(65535, 65535, 65535, 0, 16'h0000, 16'h0000);
      send_pixel(0, 0);
      send_pixel(4095, 4095);
      send_pixel(12'hAAA, 12'h555);
      // unknown register indexes must be ignored
      drain_pipeline();
      write_lens_reg(REG_SPARE_LO, 16'h1234);
      write_lens_reg(REG_SPARE_HI, 16'hFFFF);
      send_pixel(12'h555, 12'hAAA);
      send_pixel(1, 1);
   endtask

   task automatic test_random_pixels(input int count);
      for (int i = 0; i < count; i++)
         send_pixel(rldm_pkg::COORD_BITS'($urandom_range(4095)),
                    rldm_pkg::COORD_BITS'($urandom_range(4095)));
   endtask

   task automatic test_random_lenses();
      for (int p = 0; p < 6; p++) begin
         set_lens(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                  16'($urandom_range(65535)), 16'($urandom_range(65535)),
                  16'($urandom_range(65535)), 16'($urandom_range(65535)));
         test_random_pixels(40);
      end
      // realistic camera, k1 = -4915
      set_lens(16'd8000, 16'd7600, 16'd5120, 16'd3840, 16'hECCD, 16'd1638);
      test_random_pixels(120);
   endtask

   task automatic test_back_to_back();
      calm_sender = 1'b1;
      test_random_pixels(120);
      calm_sender = 1'b0;
      drain_pipeline();
      test_random_pixels(100);
   endtask

   initial begin
      lens_fx = 16'd8000;
      lens_fy = 16'd8000;
      lens_cx = 16'd5120;
      lens_cy = 16'd3840;
      lens_k1 = -16'sd4915;
      lens_k2 = 16'sd1638;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_reset_defaults();
      test_corners_and_extremes();
      test_random_lenses();
      test_back_to_back();
      drain_pipeline();
      $display("covered %0d pixel transactions, %0d register writes, %0d results checked",
               point_count, config_count, checked_count);
      $display("lens settings spanned zero and full-scale focal, center and k1/k2 values");
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
